// File: rtl/core/imec_pkg.sv
// Shared types and constants for the inverted Mandelbrot escape counter.
`timescale 1ns / 1ps
package imec_pkg;

    localparam int FRAC_BITS  = 28;
    localparam int COUNT_BITS = 16;

    // Long division runs one quotient bit per cycle over numerator and fraction bits
    localparam int DIV_STEPS = 32 + 2 * FRAC_BITS;
    localparam int STEP_W    = $clog2(DIV_STEPS);
    localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(DIV_STEPS - 1);

    // Sequencing of the denominator squares and of one 64x64 product
    localparam logic [STEP_W-1:0] DEN_LAST = STEP_W'(2);
    localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(5);

    // Escape bound |z|^2 >= 4 in the iteration format
    localparam logic [63:0] ESCAPE_BOUND = 64'd4 << FRAC_BITS;

    // Quotient clamp points
    localparam logic [33:0] Q_OVER    = 34'h1_0000_0000;
    localparam logic [33:0] Q_STICKY  = 34'h1_0000_0001;
    localparam logic [33:0] Q_POS_MAX = 34'h0_7FFF_FFFF;
    localparam logic [33:0] Q_NEG_MAX = 34'h0_8000_0000;

    // Configuration register indexes and reset values
    localparam logic REG_ITER_LIMIT = 1'b0;
    localparam logic [COUNT_BITS-1:0] ITER_LIMIT_RESET = COUNT_BITS'(100);

    // Which product the shared multiplier forms
    typedef enum logic [1:0] {
        MUL_RR = 2'd0,
        MUL_II = 2'd1,
        MUL_RI = 2'd2
    } mul_op_t;

    // Which inverted part the divider produces
    typedef enum logic {
        DIV_REAL = 1'b0,
        DIV_IMAG = 1'b1
    } div_sel_t;

    typedef struct packed {
        logic              capture;
        logic              den_step;
        logic              div_load;
        logic              div_step;
        logic              div_store;
        div_sel_t          div_sel;
        logic              iter_init;
        logic              mul_step;
        mul_op_t           mul_op;
        logic              iter_update;
        logic              zero_result;
        logic              out_load;
        logic [STEP_W-1:0] step;
    } imec_cmd_t;

    typedef struct packed {
        logic den_zero;
        logic below_limit;
        logic escaped;
    } imec_status_t;

endpackage

// File: rtl/core/imec_dpath.sv
// Datapath: squares, shared long divider, shared 32x32 multiplier and iteration registers.
`timescale 1ns / 1ps
module imec_dpath
    import imec_pkg::*;
(
    input  logic                  aclk,
    input  imec_cmd_t             cmd,
    input  logic [63:0]           in_data,
    input  logic [COUNT_BITS-1:0] iter_limit,
    output imec_status_t          status,
    output logic [15:0]           out_count,
    output logic                  out_reached
);

    logic signed [31:0] re_reg, im_reg;
    logic [31:0]        mre, mim;
    logic [63:0]        den_reg;
    logic [63:0]        prod_reg;
    logic [1:0]         pshift_reg;
    logic [127:0]       acc_reg;
    logic [64:0]        rem_reg;
    logic [31:0]        num_reg;
    logic [33:0]        quo_reg;
    logic signed [31:0] cr_reg, ci_reg;
    logic [63:0]        zr_reg, zi_reg, sqr_reg, sqi_reg, x_reg;
    logic [COUNT_BITS-1:0] n_reg;
    logic [15:0]        out_count_reg;
    logic               out_reached_reg;

    logic [63:0]  opa, opb, amag, bmag;
    logic         mneg;
    logic [31:0]  mul_x, mul_y;
    logic [127:0] shifted;
    logic [63:0]  mres, mres_signed;
    logic [64:0]  rtrial;
    logic         qbit;
    logic [33:0]  qnext, qsat;
    logic [31:0]  cval;
    logic         cneg;

    // Operand magnitudes
    assign mre = re_reg[31] ? 32'(-re_reg) : 32'(re_reg);
    assign mim = im_reg[31] ? 32'(-im_reg) : 32'(im_reg);

    // Select product operands
    always_comb begin
        unique case (cmd.mul_op)
            MUL_RR:  begin opa = zr_reg;       opb = zr_reg; end
            MUL_II:  begin opa = zi_reg;       opb = zi_reg; end
            MUL_RI:  begin opa = zr_reg << 1;  opb = zi_reg; end
            default: begin opa = zr_reg;       opb = zi_reg; end
        endcase
        amag = opa[63] ? 64'(0 - opa) : opa;
        bmag = opb[63] ? 64'(0 - opb) : opb;
        mneg = opa[63] ^ opb[63];
    end

    // Feed the multiplier: denominator squares or one partial product
    always_comb begin
        if (cmd.den_step) begin
            mul_x = cmd.step[0] ? mim : mre;
            mul_y = mul_x;
        end else begin
            mul_x = cmd.step[0] ? amag[63:32] : amag[31:0];
            mul_y = cmd.step[1] ? bmag[63:32] : bmag[31:0];
        end
    end

    // Align the held partial product
    always_comb begin
        unique case (pshift_reg)
            2'd0:    shifted = {64'd0, prod_reg};
            2'd1:    shifted = {32'd0, prod_reg, 32'd0};
            default: shifted = {prod_reg, 64'd0};
        endcase
    end

    // Truncate the magnitude product and restore the sign
    assign mres        = {2'b00, acc_reg[FRAC_BITS +: 62]};
    assign mres_signed = mneg ? 64'(0 - mres) : mres;

    // One restoring division step with quotient clamp
    always_comb begin
        rtrial = {rem_reg[63:0], num_reg[31]};
        qbit   = (rtrial >= {1'b0, den_reg});
        qnext  = {quo_reg[32:0], qbit};
        if (qnext > Q_OVER) begin
            qnext = Q_STICKY;
        end
    end

    // Saturate and sign the finished quotient
    always_comb begin
        cneg = (cmd.div_sel == DIV_REAL) ? (!im_reg[31] && (im_reg != 32'sd0)) : re_reg[31];
        if (cneg) begin
            qsat = (quo_reg > Q_NEG_MAX) ? Q_NEG_MAX : quo_reg;
            cval = 32'(0 - qsat[31:0]);
        end else begin
            qsat = (quo_reg > Q_POS_MAX) ? Q_POS_MAX : quo_reg;
            cval = qsat[31:0];
        end
    end

    // Advance datapath registers on controller commands
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            re_reg <= in_data[31:0];
            im_reg <= in_data[63:32];
        end
        if (cmd.den_step || cmd.mul_step) begin
            prod_reg   <= mul_x * mul_y;
            pshift_reg <= 2'(cmd.step[0]) + 2'(cmd.step[1]);
        end
        if (cmd.den_step) begin
            if (cmd.step == STEP_W'(1)) begin
                den_reg <= prod_reg;
            end else if (cmd.step == DEN_LAST) begin
                den_reg <= den_reg + prod_reg;
            end
        end
        if (cmd.mul_step) begin
            if (cmd.step == STEP_W'(0)) begin
                acc_reg <= '0;
            end else if (cmd.step != MUL_LAST) begin
                acc_reg <= acc_reg + shifted;
            end
            if (cmd.step == MUL_LAST) begin
                unique case (cmd.mul_op)
                    MUL_RR:  sqr_reg <= mres_signed;
                    MUL_II:  sqi_reg <= mres_signed;
                    default: x_reg   <= mres_signed;
                endcase
            end
        end
        if (cmd.div_load) begin
            rem_reg <= '0;
            quo_reg <= '0;
            num_reg <= (cmd.div_sel == DIV_REAL) ? mim : mre;
        end else if (cmd.div_step) begin
            rem_reg <= qbit ? 65'(rtrial - {1'b0, den_reg}) : rtrial;
            quo_reg <= qnext;
            num_reg <= num_reg << 1;
        end
        if (cmd.div_store) begin
            if (cmd.div_sel == DIV_REAL) begin
                cr_reg <= cval;
            end else begin
                ci_reg <= cval;
            end
        end
        if (cmd.iter_init) begin
            zr_reg <= '0;
            zi_reg <= '0;
            n_reg  <= '0;
        end else if (cmd.iter_update) begin
            zr_reg <= sqr_reg - sqi_reg + 64'(signed'(cr_reg));
            zi_reg <= x_reg + 64'(signed'(ci_reg));
            n_reg  <= n_reg + COUNT_BITS'(1);
        end else if (cmd.zero_result) begin
            n_reg  <= (iter_limit != '0) ? COUNT_BITS'(1) : '0;
        end
        if (cmd.out_load) begin
            out_count_reg   <= 16'(n_reg);
            out_reached_reg <= (n_reg == iter_limit);
        end
    end

    assign status.den_zero    = (den_reg == 64'd0);
    assign status.below_limit = (n_reg < iter_limit);
    assign status.escaped     = ((sqr_reg + sqi_reg) >= ESCAPE_BOUND);
    assign out_count          = out_count_reg;
    assign out_reached        = out_reached_reg;

endmodule

// File: rtl/core/imec_ctrl.sv
// Controller: sequences inversion, division and iteration, and owns the handshakes.
`timescale 1ns / 1ps
module imec_ctrl
    import imec_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    output logic         m_valid,
    input  logic         m_ready,
    input  imec_status_t status,
    output imec_cmd_t    cmd
);

    typedef enum logic [9:0] {
        ST_IDLE      = 10'b00_0000_0001,
        ST_DEN       = 10'b00_0000_0010,
        ST_DIV_LOAD  = 10'b00_0000_0100,
        ST_DIV_RUN   = 10'b00_0000_1000,
        ST_DIV_STORE = 10'b00_0001_0000,
        ST_CHECK     = 10'b00_0010_0000,
        ST_MUL       = 10'b00_0100_0000,
        ST_TEST      = 10'b00_1000_0000,
        ST_UPDATE    = 10'b01_0000_0000,
        ST_DONE      = 10'b10_0000_0000
    } state_t;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    div_sel_t          sel_reg, sel_next;
    mul_op_t           op_reg, op_next;
    logic              m_valid_reg, m_valid_next;
    logic              s_fire, slot_free;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign slot_free = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;

    // Next state and commands
    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg + STEP_W'(1);
        sel_next     = sel_reg;
        op_next      = op_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        cmd.step     = step_reg;
        cmd.div_sel  = sel_reg;
        cmd.mul_op   = op_reg;
        unique case (state_reg)
            ST_IDLE: begin
                step_next = '0;
                if (s_fire) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DEN;
                end
            end
            ST_DEN: begin
                cmd.den_step = 1'b1;
                if (step_reg == DEN_LAST) begin
                    sel_next   = DIV_REAL;
                    state_next = ST_DIV_LOAD;
                end
            end
            ST_DIV_LOAD: begin
                step_next = '0;
                if (status.den_zero) begin
                    cmd.zero_result = 1'b1;
                    state_next      = ST_DONE;
                end else begin
                    cmd.div_load = 1'b1;
                    state_next   = ST_DIV_RUN;
                end
            end
            ST_DIV_RUN: begin
                cmd.div_step = 1'b1;
                if (step_reg == DIV_LAST) begin
                    state_next = ST_DIV_STORE;
                end
            end
            ST_DIV_STORE: begin
                cmd.div_store = 1'b1;
                if (sel_reg == DIV_REAL) begin
                    sel_next   = DIV_IMAG;
                    state_next = ST_DIV_LOAD;
                end else begin
                    cmd.iter_init = 1'b1;
                    state_next    = ST_CHECK;
                end
            end
            ST_CHECK: begin
                step_next = '0;
                op_next   = MUL_RR;
                state_next = status.below_limit ? ST_MUL : ST_DONE;
            end
            ST_MUL: begin
                cmd.mul_step = 1'b1;
                if (step_reg == MUL_LAST) begin
                    step_next = '0;
                    unique case (op_reg)
                        MUL_RR:  op_next    = MUL_II;
                        MUL_II:  state_next = ST_TEST;
                        default: state_next = ST_UPDATE;
                    endcase
                end
            end
            ST_TEST: begin
                step_next  = '0;
                op_next    = MUL_RI;
                state_next = status.escaped ? ST_DONE : ST_MUL;
            end
            ST_UPDATE: begin
                cmd.iter_update = 1'b1;
                state_next      = ST_CHECK;
            end
            ST_DONE: begin
                if (slot_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Hold control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            sel_reg     <= DIV_REAL;
            op_reg      <= MUL_RR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            sel_reg     <= sel_next;
            op_reg      <= op_next;
            m_valid_reg <= m_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> (state_reg == ST_DEN))
        else $error("accepted transaction did not start the denominator");
    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> slot_free)
        else $error("result loaded over an untaken result");
    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_valid_reg)
        else $error("loaded result not presented");
    a_div_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV_RUN) |-> (step_reg <= DIV_LAST))
        else $error("division step count overran");
`endif

endmodule

// File: rtl/core/inverted_mandelbrot_escape_count_unit.sv
// Top level: stream ports, limit register and controller/datapath pair.
//
// Channel   Dir  Contents
// s_axis    in   tdata[31:0] point_real, tdata[63:32] point_imag (Q4.28)
// m_axis    out  tdata[15:0] escape_count, tuser[0] reached_limit
// apb       in   register 0 at address 0: iteration_limit (reset 100)
//
// A point runs from its accepting cycle to the result through the denominator squares,
// two divider passes (load, 88 quotient bits, store), then per iteration a limit check
// and three products on the one 32x32 multiplier (12 partials), then the last limit
// check and the output load. An escaping point leaves after its escape test, and a zero
// point skips division and iteration. Reset is synchronous, active low. An untaken
// result stalls the controller before the output load; input is taken only while idle.
`timescale 1ns / 1ps
module inverted_mandelbrot_escape_count_unit
    import imec_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // point_real, point_imag
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // escape_count
    output logic [0:0]  m_axis_tuser,   // reached_limit
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [COUNT_BITS-1:0] limit_reg;
    imec_cmd_t             cmd;
    imec_status_t          status;
    logic                  reached;

    // Write the iteration limit
    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= ITER_LIMIT_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == REG_ITER_LIMIT)) begin
            limit_reg <= pwdata[COUNT_BITS-1:0];
        end
    end
    assign prdata = (paddr[2] == REG_ITER_LIMIT) ? 32'(limit_reg) : 32'd0;

    imec_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .status  (status),
        .cmd     (cmd)
    );

    imec_dpath u_dpath (
        .aclk        (aclk),
        .cmd         (cmd),
        .in_data     (s_axis_tdata),
        .iter_limit  (limit_reg),
        .status      (status),
        .out_count   (m_axis_tdata),
        .out_reached (reached)
    );

    assign m_axis_tuser = reached;

endmodule

// File: bench/testbench.sv
// Self-checking bench for the inverted Mandelbrot escape counter.
`timescale 1ns / 1ps
module testbench;
    import imec_pkg::*;

    localparam longint CYCLE_LIMIT = 4000000;
    localparam int     LONG_HOLD   = 3000;

    typedef struct packed {
        logic [31:0] imag;
        logic [31:0] real_part;
    } point_t;

    typedef struct packed {
        logic [15:0] count;
        logic        at_limit;
    } escape_t;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // point_real, point_imag
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // escape_count
    logic [0:0]  m_axis_tuser;   // reached_limit
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    inverted_mandelbrot_escape_count_unit dut (.*);

    point_t          points_pending[$];
    escape_t         escapes_due[$];
    logic [15:0]     limit_shadow;
    int              errors;
    longint          cycles;
    bit              took;
    int              hold_requests;

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Inverted part: |num| * 2^(2F) / den, truncated, then saturated and signed
    function automatic longint invert_part(logic [63:0] mag, bit neg, logic [63:0] den);
        logic [127:0] num;
        logic [127:0] q;
        num = {64'd0, mag} << (2 * FRAC_BITS);
        q   = num / {64'd0, den};
        if (neg) begin
            if (q > 128'h8000_0000) q = 128'h8000_0000;
            return -longint'(q[63:0]);
        end
        if (q > 128'h7FFF_FFFF) q = 128'h7FFF_FFFF;
        return longint'(q[63:0]);
    endfunction

    // Fixed-point product, magnitude truncated toward zero
    function automatic longint fixed_mul(longint a, longint b);
        logic [63:0]  ua;
        logic [63:0]  ub;
        logic [127:0] p;
        logic [63:0]  r;
        ua = a < 0 ? 64'(-a) : 64'(a);
        ub = b < 0 ? 64'(-b) : 64'(b);
        p  = {64'd0, ua} * {64'd0, ub};
        r  = 64'(p >> FRAC_BITS);
        r[63:62] = 2'b00;
        return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
    endfunction

    function automatic escape_t predict_escape(point_t pt, logic [15:0] lim);
        longint      re;
        longint      im;
        logic [63:0] mre;
        logic [63:0] mim;
        logic [63:0] den;
        longint      cr;
        longint      ci;
        longint      zr;
        longint      zi;
        longint      nr;
        int unsigned n;
        escape_t     res;
        re  = longint'(signed'(pt.real_part));
        im  = longint'(signed'(pt.imag));
        mre = re < 0 ? 64'(-re) : 64'(re);
        mim = im < 0 ? 64'(-im) : 64'(im);
        den = mre * mre + mim * mim;
        n   = 0;
        if (den == 0) begin
            n = (lim >= 1) ? 1 : 0;
        end else begin
            cr = invert_part(mim, im > 0, den);
            ci = invert_part(mre, re < 0, den);
            zr = 0;
            zi = 0;
            while (n < lim &&
                   fixed_mul(zr, zr) + fixed_mul(zi, zi) < longint'(ESCAPE_BOUND)) begin
                nr = fixed_mul(zr, zr) - fixed_mul(zi, zi) + cr;
                zi = fixed_mul(zr * 2, zi) + ci;
                zr = nr;
                n++;
            end
        end
        res.count    = n[15:0];
        res.at_limit = (n == lim);
        return res;
    endfunction

    // Driver: bursts of transactions separated by random gaps
    int burst_left;
    int gap_left;
    always @(negedge aclk) begin
        logic        nxt_valid;
        logic [63:0] nxt_data;
        nxt_valid = s_axis_tvalid;
        nxt_data  = s_axis_tdata;
        if (aresetn && (!s_axis_tvalid || took)) begin
            nxt_valid = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (points_pending.size() > 0) begin
                nxt_data  = points_pending.pop_front();
                nxt_valid = 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 12);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 40);
                end
            end
        end
        s_axis_tvalid <= nxt_valid;
        s_axis_tdata  <= nxt_data;
    end

    // Receiver: own stall pattern, plus a long hold-off on request
    int hold_served;
    int hold_left;
    int stall_phase;
    always @(negedge aclk) begin
        logic rdy;
        stall_phase++;
        if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left   = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
        end else if (stall_phase % 64 < 24) begin
            rdy = 1'b1;
        end else begin
            rdy = ($urandom_range(0, 2) != 0);
        end
        m_axis_tready <= rdy;
    end

    // Monitor: predict on input transactions, check result transactions
    always @(posedge aclk) begin
        escape_t got;
        escape_t want;
        cycles++;
        took = s_axis_tvalid && s_axis_tready;
        if (took) escapes_due.push_back(predict_escape(s_axis_tdata, limit_shadow));
        if (m_axis_tvalid && m_axis_tready) begin
            got.count    = m_axis_tdata;
            got.at_limit = m_axis_tuser[0];
            if (escapes_due.size() == 0) begin
                $display("%0t: unexpected result count=%0d limit_flag=%0b",
                         $time, got.count, got.at_limit);
                errors++;
            end else begin
                want = escapes_due.pop_front();
                if (got.count !== want.count) begin
                    $display("%0t: escape_count expected %0d actual %0d",
                             $time, want.count, got.count);
                    errors++;
                end
                if (got.at_limit !== want.at_limit) begin
                    $display("%0t: reached_limit expected %0b actual %0b",
                             $time, want.at_limit, got.at_limit);
                    errors++;
                end
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic add_point(logic [31:0] re, logic [31:0] im);
        point_t pt;
        pt.real_part = re;
        pt.imag      = im;
        points_pending.push_back(pt);
    endtask

    // Random part value spread over magnitudes that matter after inversion
    function automatic logic [31:0] random_part();
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0: v = $urandom();
            1: v = $urandom_range(0, 255);
            2: v = 32'($urandom_range(0, 32'h1000_0000)) << 1;
            3: v = 32'h1000_0000 + $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
            4: v = $urandom_range(0, 32'h0800_0000);
            default: v = 32'h2000_0000 + $urandom_range(0, 32'h1000_0000);
        endcase
        if ($urandom_range(0, 1)) v = -v;
        return v;
    endfunction

    task automatic wait_idle();
        while (points_pending.size() > 0 || s_axis_tvalid || escapes_due.size() > 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_limit(logic [15:0] value);
        @(negedge aclk);
        psel   <= 1'b1;
        pwrite <= 1'b1;
        paddr  <= 3'(4 * REG_ITER_LIMIT);
        pwdata <= {16'($urandom_range(0, 65535)), value};
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        limit_shadow = value;
    endtask

    task automatic random_phase(logic [15:0] value, int items);
        write_limit(value);
        repeat (items) add_point(random_part(), random_part());
        wait_idle();
    endtask

    initial begin
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        limit_shadow  = ITER_LIMIT_RESET;
        errors        = 0;
        cycles        = 0;
        hold_requests = 0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: reset limit, field extremes, zero point, unit points
        add_point(32'h0, 32'h0);
        add_point(32'h8000_0000, 32'h8000_0000);
        add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_point(32'h8000_0000, 32'h7FFF_FFFF);
        add_point(32'h0000_0001, 32'h0);
        add_point(32'h0, 32'hFFFF_FFFF);
        add_point(32'h1000_0000, 32'h0);
        add_point(32'hF000_0000, 32'h0);
        add_point(32'h0, 32'h1000_0000);
        add_point(32'h0800_0000, 32'h0800_0000);
        add_point(32'hFFFF_FFFF, 32'h0000_0001);
        add_point(32'h2000_0000, 32'hE000_0000);
        wait_idle();

        // Zero limit: no iteration at all
        write_limit(16'd0);
        add_point(32'h0, 32'h0);
        add_point(32'h1000_0000, 32'h0);
        add_point(32'h0000_0001, 32'h8000_0000);
        wait_idle();

        // Limit of one, zero point included
        write_limit(16'd1);
        add_point(32'h0, 32'h0);
        add_point(32'h1000_0000, 32'h1000_0000);
        add_point(32'h0000_0002, 32'h0);
        wait_idle();

        // Largest limit with points that escape at once
        write_limit(16'hFFFF);
        add_point(32'h0, 32'h0);
        add_point(32'h0000_0001, 32'h0000_0001);
        add_point(32'hFFFF_FF00, 32'h0000_0100);
        add_point(32'h0000_0010, 32'hFFFF_FFF0);
        wait_idle();

        // Fill the block while the receiver holds off
        write_limit(16'd5);
        hold_requests++;
        repeat (30) add_point(random_part(), random_part());
        wait_idle();

        random_phase(16'd30, 300);
        random_phase(16'd7, 250);
        random_phase(16'd100, 100);
        random_phase(16'd2, 50);

        repeat (200) @(posedge aclk);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/imec_pkg.sv
rtl/core/imec_dpath.sv
rtl/core/imec_ctrl.sv
rtl/core/inverted_mandelbrot_escape_count_unit.sv
bench/testbench.sv
